FILE: rtl/pmsfp_pkg.sv
// Shared types and constants for the particulate sensor frame parser.
package pmsfp_pkg;

    localparam int POS_W = 5;

    localparam logic [7:0] HDR_FIRST  = 8'h42;
    localparam logic [7:0] HDR_SECOND = 8'h4D;
    localparam logic [7:0] LEN_SHORT  = 8'(2 * 9 + 2);
    localparam logic [7:0] LEN_LONG   = 8'(2 * 13 + 2);

    // Position of the first data byte; checksum positions follow the data.
    localparam logic [POS_W-1:0] DATA_START   = POS_W'(4);
    localparam logic [POS_W-1:0] CK_HI_SHORT  = POS_W'(2 * 9 + 2 + 2);
    localparam logic [POS_W-1:0] CK_LO_SHORT  = POS_W'(2 * 9 + 2 + 3);
    localparam logic [POS_W-1:0] CK_HI_LONG   = POS_W'(2 * 13 + 2 + 2);
    localparam logic [POS_W-1:0] CK_LO_LONG   = POS_W'(2 * 13 + 2 + 3);

    localparam int PAYLOAD_BYTES_DEF = 12;
    localparam int QUEUE_DEPTH_DEF   = 4;

    typedef enum logic [2:0] {
        TAG_START,
        TAG_ADD,
        TAG_STORE,
        TAG_CK_HI,
        TAG_CK_LO
    } t_tag;

    typedef enum logic [2:0] {
        ST_HUNT,
        ST_HDR2,
        ST_LEN_HI,
        ST_LEN_LO,
        ST_BODY
    } t_front_state;

    typedef struct packed {
        t_tag             tag;
        logic [7:0]       data;
        logic [POS_W-1:0] idx;
    } t_qword;

endpackage

FILE: rtl/pmsfp_front.sv
// Front end: frame hunt, length check and byte classification.
module pmsfp_front #(
    parameter int PAYLOAD_BYTES = pmsfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_rx_byte,
    output logic              o_stall,
    input  logic              i_full,
    output logic              o_push,
    output pmsfp_pkg::t_qword o_word
);

    pmsfp_pkg::t_front_state r_state, n_state;
    logic [pmsfp_pkg::POS_W-1:0] r_pos, n_pos;
    logic r_hi_zero, n_hi_zero;
    logic r_long, n_long;

    logic w_acc;
    logic w_len_ok;
    logic [pmsfp_pkg::POS_W-1:0] w_ck_hi_pos;
    logic [pmsfp_pkg::POS_W-1:0] w_ck_lo_pos;
    logic [pmsfp_pkg::POS_W-1:0] w_idx;

    assign o_stall = i_full;
    assign w_acc   = i_valid && !i_full;

    assign w_len_ok = r_hi_zero &&
                      (i_rx_byte == pmsfp_pkg::LEN_SHORT || i_rx_byte == pmsfp_pkg::LEN_LONG);
    assign w_ck_hi_pos = r_long ? pmsfp_pkg::CK_HI_LONG : pmsfp_pkg::CK_HI_SHORT;
    assign w_ck_lo_pos = r_long ? pmsfp_pkg::CK_LO_LONG : pmsfp_pkg::CK_LO_SHORT;
    assign w_idx       = r_pos - pmsfp_pkg::DATA_START;

    // next state
    always_comb begin
        n_state   = r_state;
        n_pos     = r_pos;
        n_hi_zero = r_hi_zero;
        n_long    = r_long;
        if (w_acc) begin
            unique case (r_state)
                pmsfp_pkg::ST_HUNT: begin
                    if (i_rx_byte == pmsfp_pkg::HDR_FIRST) n_state = pmsfp_pkg::ST_HDR2;
                end
                pmsfp_pkg::ST_HDR2: begin
                    n_state = (i_rx_byte == pmsfp_pkg::HDR_SECOND) ?
                              pmsfp_pkg::ST_LEN_HI : pmsfp_pkg::ST_HUNT;
                end
                pmsfp_pkg::ST_LEN_HI: begin
                    n_state   = pmsfp_pkg::ST_LEN_LO;
                    n_hi_zero = (i_rx_byte == 8'h00);
                end
                pmsfp_pkg::ST_LEN_LO: begin
                    n_state = w_len_ok ? pmsfp_pkg::ST_BODY : pmsfp_pkg::ST_HUNT;
                    n_long  = (i_rx_byte == pmsfp_pkg::LEN_LONG);
                    n_pos   = pmsfp_pkg::DATA_START;
                end
                pmsfp_pkg::ST_BODY: begin
                    n_pos = r_pos + 1'b1;
                    if (r_pos == w_ck_lo_pos) n_state = pmsfp_pkg::ST_HUNT;
                end
                default: n_state = pmsfp_pkg::ST_HUNT;
            endcase
        end
    end

    // classification of the accepted word
    always_comb begin
        o_push      = 1'b0;
        o_word.tag  = pmsfp_pkg::TAG_ADD;
        o_word.data = i_rx_byte;
        o_word.idx  = w_idx;
        unique case (r_state)
            pmsfp_pkg::ST_HUNT: begin
                o_push     = w_acc && (i_rx_byte == pmsfp_pkg::HDR_FIRST);
                o_word.tag = pmsfp_pkg::TAG_START;
            end
            pmsfp_pkg::ST_HDR2: begin
                o_push = w_acc && (i_rx_byte == pmsfp_pkg::HDR_SECOND);
            end
            pmsfp_pkg::ST_LEN_HI: begin
                o_push = w_acc;
            end
            pmsfp_pkg::ST_LEN_LO: begin
                o_push = w_acc && w_len_ok;
            end
            pmsfp_pkg::ST_BODY: begin
                o_push = w_acc;
                priority if (r_pos == w_ck_hi_pos) begin
                    o_word.tag = pmsfp_pkg::TAG_CK_HI;
                end else if (r_pos == w_ck_lo_pos) begin
                    o_word.tag = pmsfp_pkg::TAG_CK_LO;
                end else if (int'(w_idx) < PAYLOAD_BYTES) begin
                    o_word.tag = pmsfp_pkg::TAG_STORE;
                end else begin
                    o_word.tag = pmsfp_pkg::TAG_ADD;
                end
            end
            default: o_push = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= pmsfp_pkg::ST_HUNT;
            r_pos     <= '0;
            r_hi_zero <= 1'b0;
            r_long    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pos     <= n_pos;
            r_hi_zero <= n_hi_zero;
            r_long    <= n_long;
        end
    end

`ifndef SYNTHESIS
    a_body_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == pmsfp_pkg::ST_BODY |-> (r_pos >= pmsfp_pkg::DATA_START) &&
                                          (r_pos <= w_ck_lo_pos))
        else $error("frame position left the body range");
    a_ck_lo_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_word.tag == pmsfp_pkg::TAG_CK_LO |=> r_state == pmsfp_pkg::ST_HUNT)
        else $error("hunt did not restart after checksum");
`endif

endmodule

FILE: rtl/pmsfp_queue.sv
// Short queue of classified words between front and back end.
module pmsfp_queue #(
    parameter int QUEUE_DEPTH = pmsfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pmsfp_pkg::t_qword i_word,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output pmsfp_pkg::t_qword o_head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(QUEUE_DEPTH - 1);

    pmsfp_pkg::t_qword r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) n_wr = (r_wr == LAST) ? '0 : r_wr + 1'b1;
        if (i_pop)  n_rd = (r_rd == LAST) ? '0 : r_rd + 1'b1;
        unique case ({i_push, i_pop})
            2'b10:   n_cnt = r_cnt + 1'b1;
            2'b01:   n_cnt = r_cnt - 1'b1;
            default: n_cnt = r_cnt;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/pmsfp_back.sv
// Back end: running sum, payload store, checksum compare and result register.
module pmsfp_back #(
    parameter int PAYLOAD_BYTES = pmsfp_pkg::PAYLOAD_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  pmsfp_pkg::t_qword i_head,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [15:0]       o_pm_std_1_0,
    output logic [15:0]       o_pm_std_2_5,
    output logic [15:0]       o_pm_std_10_0,
    output logic [15:0]       o_pm_atm_1_0,
    output logic [15:0]       o_pm_atm_2_5,
    output logic [15:0]       o_pm_atm_10_0
);

    localparam int IDX_W = $clog2(PAYLOAD_BYTES);

    logic [7:0]  r_store [PAYLOAD_BYTES];
    logic [15:0] r_sum;
    logic [7:0]  r_ck_hi;
    logic        r_out_valid, n_out_valid;
    logic [15:0] r_out [6];

    logic w_out_free;
    logic w_match;
    logic w_emit;

    assign w_out_free = !r_out_valid || !i_stall;
    // hold a checksum word at the head while the result register is occupied and stalled
    assign o_pop   = !i_empty && (i_head.tag != pmsfp_pkg::TAG_CK_LO || w_out_free);
    assign w_match = (r_sum == {r_ck_hi, i_head.data});
    assign w_emit  = o_pop && (i_head.tag == pmsfp_pkg::TAG_CK_LO) && w_match;

    always_comb begin
        priority if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            unique case (i_head.tag)
                pmsfp_pkg::TAG_START: r_sum <= {8'h00, i_head.data};
                pmsfp_pkg::TAG_ADD:   r_sum <= r_sum + {8'h00, i_head.data};
                pmsfp_pkg::TAG_STORE: begin
                    r_sum <= r_sum + {8'h00, i_head.data};
                    r_store[i_head.idx[IDX_W-1:0]] <= i_head.data;
                end
                pmsfp_pkg::TAG_CK_HI: r_ck_hi <= i_head.data;
                pmsfp_pkg::TAG_CK_LO: r_sum <= r_sum;
                default:              r_sum <= r_sum;
            endcase
        end
        if (w_emit) begin
            for (int k = 0; k < 6; k++) begin
                r_out[k] <= {r_store[2 * k], r_store[2 * k + 1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_pm_std_1_0  = r_out[0];
    assign o_pm_std_2_5  = r_out[1];
    assign o_pm_std_10_0 = r_out[2];
    assign o_pm_atm_1_0  = r_out[3];
    assign o_pm_atm_2_5  = r_out[4];
    assign o_pm_atm_10_0 = r_out[5];

`ifndef SYNTHESIS
    a_rise_on_ck: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid ##1 r_out_valid |-> $past(w_emit))
        else $error("result raised without a matching checksum");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_stall |-> !w_emit)
        else $error("pending result overwritten");
`endif

endmodule

FILE: rtl/pm_sensor_frame_parser_core.sv
// Top level of the particulate sensor frame parser.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-----------------------------
//   rx      | in        | i_valid / o_stall  | i_rx_byte
//   result  | out       | o_valid / i_stall  | o_pm_std_*, o_pm_atm_*
//
// One byte is accepted per cycle while o_stall is low; the front classifies
// it and queues it in the same cycle, and the back end retires one queued word
// per cycle while words wait; a good frame's result loads when its checksum pops.
// The result register only holds the back end when a checksum word waits;
// o_stall rises once the word queue is full.
// Reset is synchronous and active low; the payload store needs no clearing.
module pm_sensor_frame_parser_core #(
    parameter int PAYLOAD_BYTES = pmsfp_pkg::PAYLOAD_BYTES_DEF,
    parameter int QUEUE_DEPTH   = pmsfp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    output logic        o_stall,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_pm_std_1_0,
    output logic [15:0] o_pm_std_2_5,
    output logic [15:0] o_pm_std_10_0,
    output logic [15:0] o_pm_atm_1_0,
    output logic [15:0] o_pm_atm_2_5,
    output logic [15:0] o_pm_atm_10_0
);

    logic              w_push;
    logic              w_full;
    logic              w_pop;
    logic              w_empty;
    pmsfp_pkg::t_qword w_in_word;
    pmsfp_pkg::t_qword w_head;

    pmsfp_front #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .o_stall   (o_stall),
        .i_full    (w_full),
        .o_push    (w_push),
        .o_word    (w_in_word)
    );

    pmsfp_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_word  (w_in_word),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    pmsfp_back #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pm_std_1_0  (o_pm_std_1_0),
        .o_pm_std_2_5  (o_pm_std_2_5),
        .o_pm_std_10_0 (o_pm_std_10_0),
        .o_pm_atm_1_0  (o_pm_atm_1_0),
        .o_pm_atm_2_5  (o_pm_atm_2_5),
        .o_pm_atm_10_0 (o_pm_atm_10_0)
    );

endmodule

FILE: test/pm_sensor_frame_parser_core_tb.sv
// Self-checking testbench for the particulate sensor frame parser core.
module pm_sensor_frame_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PAYLOAD        = pmsfp_pkg::PAYLOAD_BYTES_DEF;
    localparam int RANDOM_WORDS   = 1150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int DIR_ROWS       = 31;

    // Byte positions in the frame before the data bytes.
    localparam logic [pmsfp_pkg::POS_W-1:0] AT_HDR_FIRST  = pmsfp_pkg::POS_W'(0);
    localparam logic [pmsfp_pkg::POS_W-1:0] AT_HDR_SECOND = pmsfp_pkg::POS_W'(1);
    localparam logic [pmsfp_pkg::POS_W-1:0] AT_LEN_HI     = pmsfp_pkg::POS_W'(2);
    localparam logic [pmsfp_pkg::POS_W-1:0] AT_LEN_LO     = pmsfp_pkg::POS_W'(3);

    // Index 0 is PM1.0 standard, index 5 is PM10 atmospheric.
    typedef logic [0:5][15:0] t_pm_set;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_pm_set    want;
    } t_rx_row;

    localparam t_pm_set NO_WANT  = '0;
    localparam t_pm_set ALL_ONES = {6{16'hFFFF}};

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_pm_std_1_0;
    logic [15:0] o_pm_std_2_5;
    logic [15:0] o_pm_std_10_0;
    logic [15:0] o_pm_atm_1_0;
    logic [15:0] o_pm_atm_2_5;
    logic [15:0] o_pm_atm_10_0;

    // Frame tracker state.
    logic [pmsfp_pkg::POS_W-1:0] fp_pos  = '0;
    logic [15:0]                 fp_len  = '0;
    logic [15:0]                 fp_sum  = '0;
    logic [15:0]                 fp_ck   = '0;
    logic [7:0]                  fp_data [PAYLOAD];

    t_pm_set readings_due [$];
    t_rx_row stim_q [$];
    int      mismatches  = 0;
    int      idle_cycles = 0;
    bit      tx_steady   = 1'b0;
    bit      rx_steady   = 1'b0;

    string pm_field [6] = '{"pm_std_1_0", "pm_std_2_5", "pm_std_10_0",
                            "pm_atm_1_0", "pm_atm_2_5", "pm_atm_10_0"};

    // Noise, wrong second header, bad length, then a good frame of all-ones data.
    t_rx_row dir_table [DIR_ROWS] = '{
        '{8'h00, 1'b0, NO_WANT},
        '{8'h42, 1'b0, NO_WANT}, '{8'h42, 1'b0, NO_WANT},
        '{8'h42, 1'b0, NO_WANT}, '{8'h4D, 1'b0, NO_WANT},
        '{8'h01, 1'b0, NO_WANT}, '{8'h14, 1'b0, NO_WANT},
        '{8'h42, 1'b0, NO_WANT}, '{8'h4D, 1'b0, NO_WANT},
        '{8'h00, 1'b0, NO_WANT}, '{8'h14, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT}, '{8'hFF, 1'b0, NO_WANT},
        '{8'h12, 1'b0, NO_WANT}, '{8'h91, 1'b1, ALL_ONES}
    };

    pm_sensor_frame_parser_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_rx_byte     (i_rx_byte),
        .o_stall       (o_stall),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_pm_std_1_0  (o_pm_std_1_0),
        .o_pm_std_2_5  (o_pm_std_2_5),
        .o_pm_std_10_0 (o_pm_std_10_0),
        .o_pm_atm_1_0  (o_pm_atm_1_0),
        .o_pm_atm_2_5  (o_pm_atm_2_5),
        .o_pm_atm_10_0 (o_pm_atm_10_0)
    );

    always #5 i_clk = ~i_clk;

    function automatic int draw_gap(bit steady);
        return steady ? 0 : $urandom_range(0, 13);
    endfunction

    function automatic void flag_mismatch(string what);
        mismatches++;
        if (mismatches <= 10) $display("tb: mismatch %0d: %s", mismatches, what);
    endfunction

    function automatic void push_byte(logic [7:0] b);
        stim_q.push_back(t_rx_row'{rx: b, typed: 1'b0, want: NO_WANT});
    endfunction

    // Advance the frame tracker by one byte; return 1 when a good frame closes.
    function automatic bit track_frame(input logic [7:0] rx, output t_pm_set got);
        int k;
        got = '0;
        case (fp_pos)
            AT_HDR_FIRST: begin
                if (rx != pmsfp_pkg::HDR_FIRST) return 1'b0;
                fp_sum = 16'(rx);
            end
            AT_HDR_SECOND: begin
                if (rx != pmsfp_pkg::HDR_SECOND) begin
                    fp_pos = AT_HDR_FIRST;
                    return 1'b0;
                end
                fp_sum = fp_sum + 16'(rx);
            end
            AT_LEN_HI: begin
                fp_sum = fp_sum + 16'(rx);
                fp_len = {rx, 8'h00};
            end
            AT_LEN_LO: begin
                fp_len = fp_len | 16'(rx);
                if (fp_len != 16'(pmsfp_pkg::LEN_SHORT) &&
                    fp_len != 16'(pmsfp_pkg::LEN_LONG)) begin
                    fp_pos = AT_HDR_FIRST;
                    return 1'b0;
                end
                fp_sum = fp_sum + 16'(rx);
            end
            default: begin
                if (16'(fp_pos) == fp_len + 16'd2) begin
                    fp_ck = {rx, 8'h00};
                end else if (16'(fp_pos) == fp_len + 16'd3) begin
                    fp_ck = fp_ck | 16'(rx);
                    fp_pos = AT_HDR_FIRST;
                    for (k = 0; k < 6; k++) got[k] = {fp_data[2*k], fp_data[2*k+1]};
                    return fp_sum == fp_ck;
                end else begin
                    // Bytes past the store only feed the sum.
                    fp_sum = fp_sum + 16'(rx);
                    if (int'(fp_pos) - 4 < PAYLOAD) fp_data[int'(fp_pos) - 4] = rx;
                end
            end
        endcase
        fp_pos = fp_pos + pmsfp_pkg::POS_W'(1);
        return 1'b0;
    endfunction

    initial begin : stimulus
        t_rx_row     row;
        t_pm_set     got;
        bit          hit;
        int          gap;
        int          k;
        int          pick;
        logic [7:0]  len;
        logic [7:0]  b;
        logic [7:0]  hi;
        logic [15:0] sum;

        for (k = 0; k < PAYLOAD; k++) fp_data[k] = 8'h00;
        for (k = 0; k < DIR_ROWS; k++) stim_q.push_back(dir_table[k]);

        // Mostly whole frames with random content; the rest noise and broken frames.
        while (stim_q.size() < DIR_ROWS + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 78) begin
                len = $urandom_range(0, 1) ? pmsfp_pkg::LEN_LONG : pmsfp_pkg::LEN_SHORT;
                sum = 16'(pmsfp_pkg::HDR_FIRST) + 16'(pmsfp_pkg::HDR_SECOND) + 16'(len);
                push_byte(pmsfp_pkg::HDR_FIRST);
                push_byte(pmsfp_pkg::HDR_SECOND);
                push_byte(8'h00);
                push_byte(len);
                for (k = 0; k < int'(len) - 2; k++) begin
                    case ($urandom_range(0, 7))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        2: b = pmsfp_pkg::HDR_FIRST;
                        default: b = 8'($urandom);
                    endcase
                    sum = sum + 16'(b);
                    push_byte(b);
                end
                if ($urandom_range(0, 5) == 0) sum = sum ^ 16'($urandom_range(1, 65535));
                push_byte(sum[15:8]);
                push_byte(sum[7:0]);
            end else if (pick < 86) begin
                repeat ($urandom_range(1, 6))
                    push_byte(($urandom_range(0, 3) == 0) ? pmsfp_pkg::HDR_FIRST :
                                                            8'($urandom));
            end else if (pick < 91) begin
                b = 8'($urandom);
                if (b == pmsfp_pkg::HDR_SECOND) b = pmsfp_pkg::HDR_FIRST;
                push_byte(pmsfp_pkg::HDR_FIRST);
                push_byte(b);
            end else if (pick < 97) begin
                len = $urandom_range(0, 1) ? pmsfp_pkg::LEN_LONG : pmsfp_pkg::LEN_SHORT;
                hi = 8'h00;
                case ($urandom_range(0, 2))
                    0: hi = 8'($urandom_range(1, 255));
                    1: begin
                        len = 8'($urandom);
                        if (len == pmsfp_pkg::LEN_SHORT || len == pmsfp_pkg::LEN_LONG)
                            len = len ^ 8'h01;
                    end
                    default: len = len ^ (8'h01 << $urandom_range(0, 7));
                endcase
                push_byte(pmsfp_pkg::HDR_FIRST);
                push_byte(pmsfp_pkg::HDR_SECOND);
                push_byte(hi);
                push_byte(len);
            end else begin
                // Cut a frame short; the bytes that follow land in its body.
                len = $urandom_range(0, 1) ? pmsfp_pkg::LEN_LONG : pmsfp_pkg::LEN_SHORT;
                push_byte(pmsfp_pkg::HDR_FIRST);
                push_byte(pmsfp_pkg::HDR_SECOND);
                push_byte(8'h00);
                push_byte(len);
                repeat ($urandom_range(0, int'(len) - 3)) push_byte(8'($urandom));
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0) begin
            row = stim_q.pop_front();
            if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
            gap = draw_gap(tx_steady);
            if (gap != 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_valid   <= 1'b1;
            i_rx_byte <= row.rx;
            do @(posedge i_clk); while (o_stall);
            hit = track_frame(row.rx, got);
            if (row.typed) readings_due.push_back(row.want);
            else if (hit) readings_due.push_back(got);
        end
        i_valid <= 1'b0;

        while (readings_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && readings_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : result_sink
        int      gap;
        int      k;
        t_pm_set seen;
        t_pm_set want;

        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
            gap = draw_gap(rx_steady);
            // Hold a presented word for the drawn number of cycles.
            if (gap != 0) begin
                i_stall <= 1'b1;
                do @(posedge i_clk); while (!o_valid);
                repeat (gap - 1) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
            seen = {o_pm_std_1_0, o_pm_std_2_5, o_pm_std_10_0,
                    o_pm_atm_1_0, o_pm_atm_2_5, o_pm_atm_10_0};
            if (readings_due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", seen));
            end else begin
                want = readings_due.pop_front();
                for (k = 0; k < 6; k++)
                    if (seen[k] !== want[k])
                        flag_mismatch($sformatf("%s expected %h got %h",
                                                pm_field[k], want[k], seen[k]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

endmodule
